### sv/krl_pkg.sv
// ----------------------------------------------------------------------------
// krl_pkg
// shared widths, operation and status codes, controller types
// ----------------------------------------------------------------------------
package krl_pkg;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 4;
    localparam int CNT_W    = 5;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_WALK,
        ST_UNLINK,
        ST_FREE,
        ST_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic walk;
        logic ins_wr;
        logic unlink;
        logic free;
        logic resp;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic walk_end;
        logic walk_hit;
        logic is_delete;
        logic out_free;
    } t_stat;

endpackage

### sv/krl_in_if.sv
// ----------------------------------------------------------------------------
// krl_in_if
// operation item channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface krl_in_if;
    logic                                valid;
    logic                                ready;
    logic [krl_pkg::KIND_W-1:0]          kind;
    logic signed [krl_pkg::DATA_W-1:0]   key;
    logic signed [krl_pkg::DATA_W-1:0]   quantity;
    logic [krl_pkg::DATA_W-1:0]          price_bits;

    modport source (output valid, kind, key, quantity, price_bits, input ready);
    modport sink   (input valid, kind, key, quantity, price_bits, output ready);
endinterface

### sv/krl_out_if.sv
// ----------------------------------------------------------------------------
// krl_out_if
// result item channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface krl_out_if;
    logic                                valid;
    logic                                ready;
    logic [krl_pkg::STATUS_W-1:0]        status;
    logic [krl_pkg::POS_W-1:0]           position;
    logic signed [krl_pkg::DATA_W-1:0]   removed_quantity;
    logic [krl_pkg::DATA_W-1:0]          removed_price_bits;
    logic [krl_pkg::CNT_W-1:0]           entry_count;
    logic                                is_empty;

    modport source (output valid, status, position, removed_quantity, removed_price_bits,
                    entry_count, is_empty, input ready);
    modport sink   (input valid, status, position, removed_quantity, removed_price_bits,
                    entry_count, is_empty, output ready);
endinterface

### sv/krl_ctrl.sv
// ----------------------------------------------------------------------------
// krl_ctrl
// operation sequencer: accept, insert write, list walk, unlink, free, respond
// ----------------------------------------------------------------------------
module krl_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [krl_pkg::KIND_W-1:0] i_in_kind,
    output logic                       o_in_ready,
    input  krl_pkg::t_stat             i_stat,
    output krl_pkg::t_cmd              o_cmd
);

    krl_pkg::t_state r_state;
    krl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= krl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            krl_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_kind == krl_pkg::KIND_INSERT) begin
                        n_state = i_stat.full ? krl_pkg::ST_RESP : krl_pkg::ST_INSERT;
                    end else if (i_in_kind == krl_pkg::KIND_SEARCH ||
                                 i_in_kind == krl_pkg::KIND_DELETE) begin
                        n_state = krl_pkg::ST_WALK;
                    end else begin
                        n_state = krl_pkg::ST_RESP;
                    end
                end
            end
            krl_pkg::ST_INSERT: n_state = krl_pkg::ST_RESP;
            krl_pkg::ST_WALK: begin
                if (i_stat.walk_end) begin
                    n_state = krl_pkg::ST_RESP;
                end else if (i_stat.walk_hit) begin
                    n_state = i_stat.is_delete ? krl_pkg::ST_UNLINK : krl_pkg::ST_RESP;
                end
            end
            krl_pkg::ST_UNLINK: n_state = krl_pkg::ST_FREE;
            krl_pkg::ST_FREE:   n_state = krl_pkg::ST_RESP;
            krl_pkg::ST_RESP: begin
                if (i_stat.out_free) begin
                    n_state = krl_pkg::ST_IDLE;
                end
            end
            default: n_state = krl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            krl_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            krl_pkg::ST_INSERT: o_cmd.ins_wr = 1'b1;
            krl_pkg::ST_WALK:   o_cmd.walk   = 1'b1;
            krl_pkg::ST_UNLINK: o_cmd.unlink = 1'b1;
            krl_pkg::ST_FREE:   o_cmd.free   = 1'b1;
            krl_pkg::ST_RESP:   o_cmd.resp   = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

### sv/krl_dpath.sv
// ----------------------------------------------------------------------------
// krl_dpath
// record stores, link store, list pointers, walk registers, result register
// ----------------------------------------------------------------------------
module krl_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  krl_pkg::t_cmd                       i_cmd,
    output krl_pkg::t_stat                      o_stat,
    input  logic [krl_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [krl_pkg::DATA_W-1:0]   i_key,
    input  logic signed [krl_pkg::DATA_W-1:0]   i_quantity,
    input  logic [krl_pkg::DATA_W-1:0]          i_price_bits,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [krl_pkg::STATUS_W-1:0]        o_status,
    output logic [krl_pkg::POS_W-1:0]           o_position,
    output logic signed [krl_pkg::DATA_W-1:0]   o_removed_quantity,
    output logic [krl_pkg::DATA_W-1:0]          o_removed_price_bits,
    output logic [krl_pkg::CNT_W-1:0]           o_entry_count,
    output logic                                o_is_empty
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = krl_pkg::DATA_W;
    localparam int PW = krl_pkg::POS_W;
    localparam int NW = krl_pkg::CNT_W;
    localparam int PXW = CW + PW;
    localparam int NXW = CW + NW;
    localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
    localparam logic [SW-1:0] LAST_SL = SW'(CAPACITY - 1);

    // stores
    logic [DW-1:0] r_key_mem   [CAPACITY];
    logic [DW-1:0] r_qty_mem   [CAPACITY];
    logic [DW-1:0] r_price_mem [CAPACITY];
    logic [SW-1:0] r_link_mem  [CAPACITY];

    logic [DW-1:0] r_rd_key;
    logic [DW-1:0] r_rd_qty;
    logic [DW-1:0] r_rd_price;
    logic [SW-1:0] r_rd_link;
    logic [SW-1:0] r_rd_slot;

    // list pointers
    logic [SW-1:0] r_head;
    logic [SW-1:0] r_tail;
    logic [SW-1:0] r_free;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_fill;

    // operation and walk registers
    logic [krl_pkg::KIND_W-1:0] r_kind;
    logic [DW-1:0]              r_key;
    logic [DW-1:0]              r_qty;
    logic [DW-1:0]              r_price;
    logic [CW-1:0]              r_idx;
    logic [SW-1:0]              r_prev;
    logic [SW-1:0]              r_cur;
    logic [SW-1:0]              r_nxt;

    // pending result
    logic [krl_pkg::STATUS_W-1:0] r_res_status;
    logic [CW-1:0]                r_res_pos;
    logic [DW-1:0]                r_res_qty;
    logic [DW-1:0]                r_res_price;

    // output register
    logic                         r_out_valid;
    logic [krl_pkg::STATUS_W-1:0] r_out_status;
    logic [PW-1:0]                r_out_pos;
    logic [DW-1:0]                r_out_qty;
    logic [DW-1:0]                r_out_price;
    logic [NW-1:0]                r_out_count;
    logic                         r_out_empty;

    logic [CW-1:0]  slot_ext;
    logic           fresh;
    logic [SW-1:0]  link_v;
    logic [SW-1:0]  rd_addr;
    logic           out_free;
    logic           walk_end;
    logic           walk_hit;
    logic           link_we;
    logic [SW-1:0]  link_wa;
    logic [SW-1:0]  link_wd;
    logic [PXW-1:0] pos_ext;
    logic [NXW-1:0] cnt_ext;

    // slots at or above the fill mark were never linked: they still chain upward
    assign slot_ext = CW'(r_rd_slot);
    assign fresh    = slot_ext >= r_fill;
    assign link_v   = fresh ? ((r_rd_slot == LAST_SL) ? '0 : r_rd_slot + 1'b1) : r_rd_link;

    assign walk_end = r_idx == r_count;
    assign walk_hit = r_rd_key == r_key;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        if (i_cmd.walk) begin
            rd_addr = link_v;
        end else if (i_kind == krl_pkg::KIND_INSERT) begin
            rd_addr = r_free;
        end else begin
            rd_addr = r_head;
        end
    end

    always_comb begin
        link_we = 1'b0;
        link_wa = r_cur;
        link_wd = r_free;
        if (i_cmd.ins_wr) begin
            link_we = r_count != '0;
            link_wa = r_tail;
            link_wd = r_rd_slot;
        end else if (i_cmd.unlink) begin
            link_we = r_idx != '0;
            link_wa = r_prev;
            link_wd = r_nxt;
        end else if (i_cmd.free) begin
            link_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            r_key_mem[r_rd_slot]   <= r_key;
            r_qty_mem[r_rd_slot]   <= r_qty;
            r_price_mem[r_rd_slot] <= r_price;
        end
        if (link_we) begin
            r_link_mem[link_wa] <= link_wd;
        end
        r_rd_key   <= r_key_mem[rd_addr];
        r_rd_qty   <= r_qty_mem[rd_addr];
        r_rd_price <= r_price_mem[rd_addr];
        r_rd_link  <= r_link_mem[rd_addr];
        r_rd_slot  <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_free      <= '0;
            r_count     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ins_wr) begin
                r_free <= link_v;
                if (r_count == '0) begin
                    r_head <= r_rd_slot;
                end
                r_tail  <= r_rd_slot;
                r_count <= r_count + 1'b1;
                if (fresh) begin
                    r_fill <= slot_ext + 1'b1;
                end
            end
            if (i_cmd.unlink) begin
                if (r_idx == '0) begin
                    r_head <= r_nxt;
                end
                if (r_cur == r_tail) begin
                    r_tail <= (r_idx == '0) ? '0 : r_prev;
                end
            end
            if (i_cmd.free) begin
                r_free  <= r_cur;
                r_count <= r_count - 1'b1;
                if (r_count == CW'(1)) begin
                    r_head <= '0;
                    r_tail <= '0;
                end
            end
            if (i_cmd.resp && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign pos_ext = PXW'(r_res_pos);
    assign cnt_ext = NXW'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind       <= i_kind;
            r_key        <= i_key;
            r_qty        <= i_quantity;
            r_price      <= i_price_bits;
            r_idx        <= '0;
            r_res_pos    <= '0;
            r_res_qty    <= '0;
            r_res_price  <= '0;
            r_res_status <= (i_kind == krl_pkg::KIND_INSERT && r_count == CAP_C)
                          ? krl_pkg::STATUS_FULL : krl_pkg::STATUS_OK;
        end
        if (i_cmd.walk) begin
            if (walk_end) begin
                r_res_status <= krl_pkg::STATUS_NOT_FOUND;
            end else if (walk_hit) begin
                r_res_pos <= r_idx;
                r_cur     <= r_rd_slot;
                r_nxt     <= link_v;
                if (r_kind == krl_pkg::KIND_DELETE) begin
                    r_res_qty   <= r_rd_qty;
                    r_res_price <= r_rd_price;
                end
            end else begin
                r_prev <= r_rd_slot;
                r_idx  <= r_idx + 1'b1;
            end
        end
        if (i_cmd.resp && out_free) begin
            r_out_status <= r_res_status;
            r_out_pos    <= pos_ext[PW-1:0];
            r_out_qty    <= r_res_qty;
            r_out_price  <= r_res_price;
            r_out_count  <= cnt_ext[NW-1:0];
            r_out_empty  <= r_count == '0;
        end
    end

    assign o_stat.full      = r_count == CAP_C;
    assign o_stat.walk_end  = walk_end;
    assign o_stat.walk_hit  = walk_hit;
    assign o_stat.is_delete = r_kind == krl_pkg::KIND_DELETE;
    assign o_stat.out_free  = out_free;

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out_status;
    assign o_position           = r_out_pos;
    assign o_removed_quantity   = r_out_qty;
    assign o_removed_price_bits = r_out_price;
    assign o_entry_count        = r_out_count;
    assign o_is_empty           = r_out_empty;

endmodule

### sv/keyed_record_list.sv
// ----------------------------------------------------------------------------
// keyed_record_list
// insertion-ordered record list with next links and a free list
// ----------------------------------------------------------------------------
// sequence: an insert writes the record at the free slot and links it after
//   the tail (a full list goes straight to the result); search and delete walk
//   from the head, and a delete hit unlinks the record and frees its slot
// throughput: one item at a time, the next item is taken once the result is
//   in the output register; the walk reads one linked entry a cycle
// reset: synchronous, no clearing pass; a fill mark replaces free-list chaining
module keyed_record_list #(
    parameter int CAPACITY = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    krl_in_if.sink         i_item,
    krl_out_if.source      o_result
);

    krl_pkg::t_cmd  cmd;
    krl_pkg::t_stat stat;

    // low bits of the capacity, as the count field shows a full list
    localparam logic [31:0] CAP_U = 32'(CAPACITY);

    // sequencer: one operation in flight, result parked in the output register
    krl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_kind  (i_item.kind),
        .o_in_ready (i_item.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // stores, pointers, walk state and result register
    krl_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_kind               (i_item.kind),
        .i_key                (i_item.key),
        .i_quantity           (i_item.quantity),
        .i_price_bits         (i_item.price_bits),
        .i_out_ready          (o_result.ready),
        .o_out_valid          (o_result.valid),
        .o_status             (o_result.status),
        .o_position           (o_result.position),
        .o_removed_quantity   (o_result.removed_quantity),
        .o_removed_price_bits (o_result.removed_price_bits),
        .o_entry_count        (o_result.entry_count),
        .o_is_empty           (o_result.is_empty)
    );

    // at most one datapath command per cycle
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command active");

    // unlinking is always finished by returning the slot to the free list
    a_unlink_then_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.unlink |=> cmd.free)
        else $error("unlink not followed by free");

    // a rejected insert reports a full list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status == krl_pkg::STATUS_FULL)
        |-> o_result.entry_count == CAP_U[krl_pkg::CNT_W-1:0])
        else $error("full status with wrong count");

    // no new item while an operation is still in progress
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.walk || cmd.ins_wr || cmd.unlink || cmd.free) |-> !i_item.ready)
        else $error("item accepted during an operation");

endmodule
